// ----- src/spa_pkg.sv -----
// -----------------------------------------------------------------------------
// spa_pkg: shared types and constants for the sparse polynomial adder
// Field widths, request kinds, and the store control bundle.
// -----------------------------------------------------------------------------
package spa_pkg;

	localparam int MAX_TERMS_DEF  = 32;
	localparam int EXPON_BITS_DEF = 10;

	localparam int KIND_W  = 2;
	localparam int COEF_W  = 16;
	localparam int SUM_W   = 17;
	localparam int EXPON_W = 10;

	// stream data widths, rounded up to whole bytes
	localparam int IN_TDATA_W  = ((COEF_W + EXPON_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((SUM_W + EXPON_W + 7) / 8) * 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_A = 2'd0,
		KIND_LOAD_B = 2'd1,
		KIND_START  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// control from the merge engine to both term stores
	typedef struct packed {
		logic rd_en;
		logic clear;
	} store_ctl_t;

endpackage

// ----- src/spa_store.sv -----
// -----------------------------------------------------------------------------
// spa_store: one term store
// Synchronous term memory with append-on-load, a registered read port and a
// fill count that the merge engine clears when it finishes.
// -----------------------------------------------------------------------------
module spa_store #(
	parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
	parameter int EW        = spa_pkg::EXPON_BITS_DEF,
	parameter int AW        = 5,
	parameter int CW        = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [spa_pkg::COEF_W-1:0] wr_coef,
	input  logic [EW-1:0]           wr_expon,
	input  spa_pkg::store_ctl_t     ctl,
	input  logic [AW-1:0]           rd_addr,
	output logic [spa_pkg::COEF_W-1:0] rd_coef,
	output logic [EW-1:0]           rd_expon,
	output logic [CW-1:0]           count
);
	import spa_pkg::*;

	localparam int DW = COEF_W + EW;

	logic [DW-1:0] mem [MAX_TERMS];
	logic [DW-1:0] rd_data_q;
	logic [CW-1:0] count_q;
	logic          wr_ok;

	assign wr_ok = wr_en && (count_q != CW'(MAX_TERMS));

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[count_q[AW-1:0]] <= {wr_expon, wr_coef};
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (wr_ok) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign rd_coef  = rd_data_q[COEF_W-1:0];
	assign rd_expon = rd_data_q[DW-1:COEF_W];
	assign count    = count_q;

endmodule

// ----- src/spa_merge.sv -----
// -----------------------------------------------------------------------------
// spa_merge: merge engine
// Walks both stores by exponent, holds one term back so the last mark can be
// set, and drives the result register.
// -----------------------------------------------------------------------------
module spa_merge #(
	parameter int EW = spa_pkg::EXPON_BITS_DEF,
	parameter int AW = 5,
	parameter int CW = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        idle,
	input  logic [CW-1:0]               cnt_a,
	input  logic [CW-1:0]               cnt_b,
	output spa_pkg::store_ctl_t         ctl,
	output logic [AW-1:0]               rd_addr_a,
	output logic [AW-1:0]               rd_addr_b,
	input  logic [spa_pkg::COEF_W-1:0]  coef_a,
	input  logic [EW-1:0]               expon_a,
	input  logic [spa_pkg::COEF_W-1:0]  coef_b,
	input  logic [EW-1:0]               expon_b,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [spa_pkg::SUM_W-1:0]   out_coef,
	output logic [spa_pkg::EXPON_W-1:0] out_expon,
	output logic                        out_has,
	output logic                        out_last
);
	import spa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_COMP  = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [CW-1:0]    ia_q, ib_q;
	logic             pend_valid_q;
	logic [SUM_W-1:0] pend_coef_q;
	logic [EW-1:0]    pend_expon_q;

	logic             out_valid_q, out_has_q, out_last_q;
	logic [SUM_W-1:0] out_coef_q;
	logic [EW-1:0]    out_expon_q;

	logic             a_has, b_has, take_a, take_b, both, done, new_valid;
	logic             out_free, stall, step, push;
	logic [SUM_W-1:0] sum, new_coef;
	logic [EW-1:0]    new_expon;

	assign a_has = ia_q < cnt_a;
	assign b_has = ib_q < cnt_b;
	assign sum   = SUM_W'(signed'(coef_a)) + SUM_W'(signed'(coef_b));

	assign take_a = a_has && (!b_has || (expon_a > expon_b));
	assign take_b = b_has && (!a_has || (expon_b > expon_a));
	assign both   = a_has && b_has && (expon_a == expon_b);
	assign done   = !a_has && !b_has;

	assign new_valid = take_a || take_b || (both && (sum != '0));
	assign new_coef  = take_a ? SUM_W'(signed'(coef_a)) :
	                   take_b ? SUM_W'(signed'(coef_b)) : sum;
	assign new_expon = take_b ? expon_b : expon_a;

	assign out_free = !out_valid_q || out_ready;
	// a push is needed at the end, or when a new term displaces the held one
	assign stall = (done || (new_valid && pend_valid_q)) && !out_free;
	assign step  = (state_q == ST_COMP) && !stall && !done;
	assign push  = (step && new_valid && pend_valid_q) ||
	               ((state_q == ST_COMP) && done && out_free);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_COMP;
			end
			ST_COMP: begin
				if (!stall) state_d = done ? ST_IDLE : ST_FETCH;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ia_q         <= '0;
			ib_q         <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_IDLE && start) begin
				ia_q         <= '0;
				ib_q         <= '0;
				pend_valid_q <= 1'b0;
			end
			if (step) begin
				if (take_a || both) ia_q <= ia_q + 1'b1;
				if (take_b || both) ib_q <= ib_q + 1'b1;
				if (new_valid) pend_valid_q <= 1'b1;
			end
			if (state_q == ST_COMP && done && out_free) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// payload: held term and result register
	always_ff @(posedge clk) begin
		if (step && new_valid) begin
			pend_coef_q  <= new_coef;
			pend_expon_q <= new_expon;
			if (pend_valid_q) begin
				out_coef_q  <= pend_coef_q;
				out_expon_q <= pend_expon_q;
				out_has_q   <= 1'b1;
				out_last_q  <= 1'b0;
			end
		end
		if (state_q == ST_COMP && done && out_free) begin
			out_coef_q  <= pend_valid_q ? pend_coef_q : '0;
			out_expon_q <= pend_valid_q ? pend_expon_q : '0;
			out_has_q   <= pend_valid_q;
			out_last_q  <= 1'b1;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign ctl.rd_en = (state_q == ST_FETCH);
	assign ctl.clear = (state_q == ST_COMP) && done && out_free;
	assign rd_addr_a = ia_q[AW-1:0];
	assign rd_addr_b = ib_q[AW-1:0];

	assign out_valid = out_valid_q;
	assign out_coef  = out_coef_q;
	assign out_expon = EXPON_W'(out_expon_q);
	assign out_has   = out_has_q;
	assign out_last  = out_last_q;

endmodule

// ----- src/sparse_polynomial_add.sv -----
// -----------------------------------------------------------------------------
// sparse_polynomial_add: sparse polynomial adder, top level
// Loads terms into two stores and merges them into a sum stream on start.
// -----------------------------------------------------------------------------
// A load request is accepted while idle and gives no result. A start
// request runs the merge: each step reads both stores (FETCH), then
// compares the exponents (COMP); a closing step emits the last item.
// s_tready is low while a merge runs, so no request is taken before it ends;
// each store has a single read port. The result register lets the engine
// keep working while one result waits on m_tready, until another must be pushed.
// Reset: counts, control and valid flags clear; store contents are kept.
module sparse_polynomial_add #(
	parameter int MAX_TERMS  = spa_pkg::MAX_TERMS_DEF,
	parameter int EXPON_BITS = spa_pkg::EXPON_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [spa_pkg::IN_TDATA_W-1:0]  s_tdata,  // term_coef[15:0], term_expon[25:16]
	input  logic [spa_pkg::KIND_W-1:0]      s_tuser,  // kind[1:0]
	// master side
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [spa_pkg::OUT_TDATA_W-1:0] m_tdata,  // sum_coef[16:0], sum_expon[26:17]
	output logic                            m_tuser,  // has_term
	output logic                            m_tlast   // last_term
);
	import spa_pkg::*;

	// exponents are kept in at most EXPON_W bits
	localparam int EW = (EXPON_BITS < EXPON_W) ? EXPON_BITS : EXPON_W;
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);

	logic              req;
	kind_t             kind;
	logic [COEF_W-1:0] term_coef;
	logic [EW-1:0]     term_expon;

	store_ctl_t        ctl;
	logic [AW-1:0]     rd_addr_a, rd_addr_b;
	logic [COEF_W-1:0] coef_a, coef_b;
	logic [EW-1:0]     expon_a, expon_b;
	logic [CW-1:0]     cnt_a, cnt_b;
	logic              idle;

	logic [SUM_W-1:0]   sum_coef;
	logic [EXPON_W-1:0] sum_expon;

	// request decode; an unused kind is taken and dropped
	assign req        = s_tvalid && s_tready;
	assign kind       = kind_t'(s_tuser);
	assign term_coef  = s_tdata[COEF_W-1:0];
	assign term_expon = s_tdata[COEF_W +: EW];
	assign s_tready   = idle;

	spa_store #(
		.MAX_TERMS(MAX_TERMS), .EW(EW), .AW(AW), .CW(CW)
	) u_store_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (req && (kind == KIND_LOAD_A)),
		.wr_coef  (term_coef),
		.wr_expon (term_expon),
		.ctl      (ctl),
		.rd_addr  (rd_addr_a),
		.rd_coef  (coef_a),
		.rd_expon (expon_a),
		.count    (cnt_a)
	);

	spa_store #(
		.MAX_TERMS(MAX_TERMS), .EW(EW), .AW(AW), .CW(CW)
	) u_store_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (req && (kind == KIND_LOAD_B)),
		.wr_coef  (term_coef),
		.wr_expon (term_expon),
		.ctl      (ctl),
		.rd_addr  (rd_addr_b),
		.rd_coef  (coef_b),
		.rd_expon (expon_b),
		.count    (cnt_b)
	);

	spa_merge #(
		.EW(EW), .AW(AW), .CW(CW)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req && (kind == KIND_START)),
		.idle      (idle),
		.cnt_a     (cnt_a),
		.cnt_b     (cnt_b),
		.ctl       (ctl),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.coef_a    (coef_a),
		.expon_a   (expon_a),
		.coef_b    (coef_b),
		.expon_b   (expon_b),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_coef  (sum_coef),
		.out_expon (sum_expon),
		.out_has   (m_tuser),
		.out_last  (m_tlast)
	);

	// pack result fields, zero fill to the byte boundary
	assign m_tdata = OUT_TDATA_W'({sum_expon, sum_coef});

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for sparse_polynomial_add
// Loads term lists into both stores over the request stream, starts the
// addition and checks every sum term against an in-bench merge predictor.
// Covers directed corner terms, full stores, random polynomials under
// several idle patterns, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spa_pkg::*;

	localparam int NTERMS = MAX_TERMS_DEF;
	// settling wait after draining, scaled with the store depth
	localparam int SETTLE_CYCLES = 4 * NTERMS + 12;

	// one term as loaded into a store
	typedef struct {
		logic signed [COEF_W-1:0]  coef;
		logic        [EXPON_W-1:0] expon;
	} term_t;

	// one expected item of the sum stream
	typedef struct {
		logic signed [SUM_W-1:0]   coef;
		logic        [EXPON_W-1:0] expon;
		logic                      has_term;
		logic                      last;
	} sum_term_t;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [KIND_W-1:0]      s_tuser  = KIND_NONE;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	sparse_polynomial_add uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// predictor copy of both term stores
	logic signed [COEF_W-1:0]  poly_a_coef  [NTERMS];
	logic        [EXPON_W-1:0] poly_a_expon [NTERMS];
	logic signed [COEF_W-1:0]  poly_b_coef  [NTERMS];
	logic        [EXPON_W-1:0] poly_b_expon [NTERMS];
	int                        terms_in_a = 0;
	int                        terms_in_b = 0;

	sum_term_t sum_q[$];          // sum terms still owed by the block

	int send_idle_pct  = 0;       // chance per cycle that the sender idles
	int ready_stall_pct = 0;      // chance per cycle that the receiver stalls
	int hold_req       = 0;       // long receiver hold-off, taken by the receiver
	int hold_left      = 0;

	int err_cnt     = 0;
	int n_requests  = 0;          // load and start requests, ignored kinds excluded
	int n_starts    = 0;
	int n_checked   = 0;
	int n_empty     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------
	function automatic void owe_term(logic signed [SUM_W-1:0] coef,
		logic [EXPON_W-1:0] expon);
		sum_q.push_back('{coef, expon, 1'b1, 1'b0});
	endfunction

	// Applies one accepted request to the predicted stores; a start request
	// merges both stores and queues the resulting sum terms.
	function automatic void apply_request(kind_t kind, logic signed [COEF_W-1:0] coef,
		logic [EXPON_W-1:0] expon);
		int ia;
		int ib;
		int n;
		logic signed [SUM_W-1:0] s;
		case (kind)
			KIND_LOAD_A: begin
				if (terms_in_a < NTERMS) begin
					poly_a_coef[terms_in_a]  = coef;
					poly_a_expon[terms_in_a] = expon;
					terms_in_a++;
				end
			end
			KIND_LOAD_B: begin
				if (terms_in_b < NTERMS) begin
					poly_b_coef[terms_in_b]  = coef;
					poly_b_expon[terms_in_b] = expon;
					terms_in_b++;
				end
			end
			KIND_START: begin
				ia = 0;
				ib = 0;
				n  = 0;
				// walk both lists, larger exponent first
				while (ia < terms_in_a && ib < terms_in_b) begin
					if (poly_a_expon[ia] < poly_b_expon[ib]) begin
						owe_term(SUM_W'(poly_b_coef[ib]), poly_b_expon[ib]);
						ib++;
						n++;
					end else if (poly_a_expon[ia] > poly_b_expon[ib]) begin
						owe_term(SUM_W'(poly_a_coef[ia]), poly_a_expon[ia]);
						ia++;
						n++;
					end else begin
						s = SUM_W'(poly_a_coef[ia]) + SUM_W'(poly_b_coef[ib]);
						// cancelled terms vanish from the sum
						if (s != 0) begin
							owe_term(s, poly_a_expon[ia]);
							n++;
						end
						ia++;
						ib++;
					end
				end
				for (; ia < terms_in_a; ia++) begin
					owe_term(SUM_W'(poly_a_coef[ia]), poly_a_expon[ia]);
					n++;
				end
				for (; ib < terms_in_b; ib++) begin
					owe_term(SUM_W'(poly_b_coef[ib]), poly_b_expon[ib]);
					n++;
				end
				// empty sum: a single marker item with no term
				if (n == 0)
					sum_q.push_back('{'0, '0, 1'b0, 1'b1});
				else
					sum_q[sum_q.size()-1].last = 1'b1;
				terms_in_a = 0;
				terms_in_b = 0;
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off counted here on request
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Result checker: each accepted item against the oldest owed sum term
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_sum
		sum_term_t want;
		logic signed [SUM_W-1:0] got_coef;
		logic [EXPON_W-1:0]      got_expon;
		if (arst_n && m_tvalid && m_tready) begin
			got_coef  = $signed(m_tdata[SUM_W-1:0]);
			got_expon = m_tdata[SUM_W +: EXPON_W];
			if (sum_q.size() == 0) begin
				$error("result with nothing owed: sum_coef %0d sum_expon %0d has_term %0b last_term %0b",
					got_coef, got_expon, m_tuser, m_tlast);
				err_cnt++;
			end else begin
				want = sum_q.pop_front();
				n_checked++;
				if (!want.has_term)
					n_empty++;
				if (got_coef !== want.coef) begin
					$error("sum_coef: expected %0d, got %0d", want.coef, got_coef);
					err_cnt++;
				end
				if (got_expon !== want.expon) begin
					$error("sum_expon: expected %0d, got %0d", want.expon, got_expon);
					err_cnt++;
				end
				if (m_tuser !== want.has_term) begin
					$error("has_term: expected %0b, got %0b", want.has_term, m_tuser);
					err_cnt++;
				end
				if (m_tlast !== want.last) begin
					$error("last_term: expected %0b, got %0b", want.last, m_tlast);
					err_cnt++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------
	// Offers one request and returns at the edge that accepts it. tvalid
	// is left high so back-to-back requests keep the stream busy; any idle
	// gap lowers it at the start of the next call.
	task automatic send_request(kind_t kind, logic [COEF_W-1:0] coef,
		logic [EXPON_W-1:0] expon);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(IN_TDATA_W-COEF_W-EXPON_W){1'b0}}, expon, coef};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_request(kind, coef, expon);
		if (kind != KIND_NONE)
			n_requests++;
		if (kind == KIND_START)
			n_starts++;
	endtask

	// Sender stops and waits until the block has delivered every sum term.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sum_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Builds two well-formed operands: distinct exponents in decreasing
	// order, with a share of exponents common to both and some of those
	// set up to cancel. A narrow exponent span raises the overlap.
	task automatic make_operands(int na, int nb, output term_t qa[$], output term_t qb[$]);
		bit          in_a[1024];
		bit          in_b[1024];
		bit          cancel[1024];
		int          a_exps[$];
		int          span;
		int          pick;
		int          e;
		logic [15:0] ca;
		logic [15:0] cb;
		qa = {};
		qb = {};
		for (e = 0; e < 1024; e++) begin
			in_a[e]   = 1'b0;
			in_b[e]   = 1'b0;
			cancel[e] = 1'b0;
		end
		pick = $urandom_range(2);
		span = (pick == 0) ? 15 : (pick == 1) ? 127 : 1023;
		if (span + 1 < na + nb)
			span = 1023;
		repeat (na) begin
			e = $urandom_range(span);
			while (in_a[e])
				e = $urandom_range(span);
			in_a[e] = 1'b1;
			a_exps.push_back(e);
		end
		repeat (nb) begin
			if (a_exps.size() != 0 && $urandom_range(1))
				e = a_exps[$urandom_range(a_exps.size()-1)];
			else
				e = $urandom_range(span);
			while (in_b[e])
				e = $urandom_range(span);
			in_b[e]   = 1'b1;
			cancel[e] = ($urandom_range(3) == 0);
		end
		for (e = 1023; e >= 0; e--) begin
			ca = COEF_W'($urandom);
			if (in_a[e])
				qa.push_back('{ca, e[EXPON_W-1:0]});
			if (in_b[e]) begin
				cb = (in_a[e] && cancel[e]) ? -ca : 16'($urandom);
				qb.push_back('{cb, e[EXPON_W-1:0]});
			end
		end
	endtask

	// Loads both operands in a random interleave, then starts the sum.
	// With noise on, ignored-kind requests are sprinkled between loads.
	task automatic load_and_add(term_t qa[$], term_t qb[$], bit noise);
		term_t t;
		while (qa.size() != 0 || qb.size() != 0) begin
			if (noise && $urandom_range(19) == 0)
				send_request(KIND_NONE, COEF_W'($urandom), EXPON_W'($urandom));
			if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1))) begin
				t = qa.pop_front();
				send_request(KIND_LOAD_A, t.coef, t.expon);
			end else begin
				t = qb.pop_front();
				send_request(KIND_LOAD_B, t.coef, t.expon);
			end
		end
		// start carries don't-care data
		send_request(KIND_START, COEF_W'($urandom), EXPON_W'($urandom));
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	// Corner terms: empty sum, single-store sums at the coefficient and
	// exponent extremes, full cancellation, sums at both ends of the
	// result range, an ignored kind and a store out of exponent order.
	task automatic test_directed();
		send_idle_pct   = 14;
		ready_stall_pct = 14;
		send_request(KIND_START, 16'hFFFF, 10'h3FF);
		send_request(KIND_LOAD_A, 16'h8000, 10'd1023);
		send_request(KIND_START, '0, '0);
		send_request(KIND_LOAD_B, 16'h7FFF, 10'd0);
		send_request(KIND_START, '0, '0);
		send_request(KIND_LOAD_A, 16'd5, 10'd3);
		send_request(KIND_LOAD_B, -16'sd5, 10'd3);
		send_request(KIND_START, '0, '0);
		send_request(KIND_LOAD_A, 16'h8000, 10'd10);
		send_request(KIND_LOAD_B, 16'h8000, 10'd10);
		send_request(KIND_LOAD_A, 16'h7FFF, 10'd7);
		send_request(KIND_LOAD_B, 16'h7FFF, 10'd7);
		send_request(KIND_START, '0, '0);
		send_request(KIND_NONE, 16'hFFFF, 10'h3FF);
		send_request(KIND_LOAD_A, 16'h5555, 10'h2AA);
		send_request(KIND_LOAD_A, 16'hAAAA, 10'h155);
		send_request(KIND_LOAD_A, 16'd1, 10'd2);
		send_request(KIND_LOAD_A, 16'd7, 10'd8);   // breaks decreasing order
		send_request(KIND_LOAD_B, 16'd4, 10'd5);
		send_request(KIND_LOAD_B, 16'd2, 10'd2);
		send_request(KIND_START, '0, '0);
		drain_results();
	endtask

	// More loads than each store holds: the excess must be dropped and the
	// sum can reach its longest length.
	task automatic test_store_capacity();
		term_t qa[$];
		term_t qb[$];
		send_idle_pct   = 0;
		ready_stall_pct = 14;
		make_operands(NTERMS + 2, NTERMS + 1, qa, qb);
		load_and_add(qa, qb, 1'b0);
		drain_results();
	endtask

	// Random polynomials under each idle pattern: mostly short operands,
	// a few long ones, now and then a store out of order.
	task automatic test_random_sums();
		int    idle_tab[4];
		int    stall_tab[4];
		int    ph;
		int    mark;
		int    na;
		int    nb;
		int    i;
		int    j;
		term_t qa[$];
		term_t qb[$];
		term_t t;
		idle_tab  = '{0, 62, 0, 14};
		stall_tab = '{0, 0, 62, 14};
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct   = idle_tab[ph];
			ready_stall_pct = stall_tab[ph];
			mark = n_requests;
			while (n_requests - mark < 25) begin
				na = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(7, 20);
				nb = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(7, 20);
				make_operands(na, nb, qa, qb);
				if ($urandom_range(9) == 0 && qa.size() > 1) begin
					i = $urandom_range(qa.size()-1);
					j = $urandom_range(qa.size()-1);
					t = qa[i];
					qa[i] = qa[j];
					qa[j] = t;
				end
				load_and_add(qa, qb, 1'b1);
			end
			drain_results();
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering
	// requests, so the block backs up and stalls its input; afterwards the
	// sender waits for every owed term.
	task automatic test_backpressure();
		term_t qa[$];
		term_t qb[$];
		send_idle_pct   = 0;
		ready_stall_pct = 0;
		hold_req        = 300;
		repeat (3) begin
			make_operands(12, 12, qa, qb);
			load_and_add(qa, qb, 1'b0);
		end
		drain_results();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_store_capacity();
		test_random_sums();
		test_backpressure();
		drain_results();
		if (sum_q.size() != 0) begin
			$error("%0d sum terms never delivered", sum_q.size());
			err_cnt++;
		end
		$display("Run covered %0d load/start requests, %0d additions started,",
			n_requests, n_starts);
		$display("and checked %0d sum items (%0d empty sums), %0d mismatches.",
			n_checked, n_empty, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
